// ===== rtl/core/gcrmt_pkg.sv =====
// Shared types, codes and sizes of the grid column/row maximum tracker.
`timescale 1ns / 1ps
`default_nettype none
package gcrmt_pkg;

	localparam int MAX_COLUMNS  = 64;
	localparam int MAX_PAGES    = 1024;
	localparam int DIM_BITS     = 20;
	localparam int COL_BITS     = $clog2(MAX_COLUMNS);
	localparam int ROW_BITS     = $clog2(MAX_PAGES);
	localparam int COUNT_BITS   = ROW_BITS + 1;
	localparam int NCOL_BITS    = COL_BITS + 1;
	localparam int VALUE_BITS   = DIM_BITS + 1;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 11;

	typedef enum logic [1:0] {
		OP_RESTART  = 2'd0,
		OP_PLACE    = 2'd1,
		OP_READ_COL = 2'd2,
		OP_READ_ROW = 2'd3
	} opcode_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_REQ_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REQ_OFFSET  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAGE_COUNT  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic finish;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/grid_column_row_max_tracker_unit.sv =====
// Top level of the grid column/row maximum tracker.
`timescale 1ns / 1ps
`default_nettype none
// Usage: an item is taken at a rising edge with start high and busy low. Its opcode
// picks restart, place page, read column width or read row height; the other fields
// are the page size in unsigned 16.4 and the queried index.
// Each item yields one result, shown for exactly one cycle with done high. The
// receiver cannot hold results off; done simply pulses and the ports keep their
// values until the next result.
// Sequence: after the accepting edge the controller passes through a read state and a
// finish state. The read state reads both tables (registered memory reads), the finish
// state compares, writes back and registers the result and done, and busy drops with
// done, so the next item is taken at the edge that ends the done cycle. A new item is
// not taken while the last one is still in the read or finish state.
// Configuration: wr_en, wr_index and wr_data write the requested column count, the
// requested offset and the page count; they take effect at the next restart item.
// Write them only while the block is idle.
// Reset: arst_n clears the controller, the grid counters, the column fill bits and
// the configuration to columns one, offset zero and no pages, so pages are ignored
// until a restart item arrives. Table contents need no reset: row fill is implied by
// the placement counters, and column fill is kept in flip-flops.
module grid_column_row_max_tracker_unit
	import gcrmt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              opcode,
	input  wire logic [DIM_BITS-1:0]     page_width,
	input  wire logic [DIM_BITS-1:0]     page_height,
	input  wire logic [ROW_BITS-1:0]     query_index,
	input  wire logic                    wr_en,
	input  wire logic [CFG_IDX_BITS-1:0] wr_index,
	input  wire logic [CFG_DAT_BITS-1:0] wr_data,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] value,
	output logic [COL_BITS-1:0]          placed_column,
	output logic [ROW_BITS-1:0]          placed_row,
	output logic [NCOL_BITS-1:0]         columns_in_use,
	output logic [COL_BITS-1:0]          offset_in_use,
	output logic [COUNT_BITS-1:0]        rows_in_use,
	output logic                         page_ignored
);

	// The controller sequences each item; the datapath holds the tables, counters and configuration.
	ctrl_cmd_t cmd;

	gcrmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	gcrmt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.opcode         (opcode),
		.page_width     (page_width),
		.page_height    (page_height),
		.query_index    (query_index),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.done           (done),
		.value          (value),
		.placed_column  (placed_column),
		.placed_row     (placed_row),
		.columns_in_use (columns_in_use),
		.offset_in_use  (offset_in_use),
		.rows_in_use    (rows_in_use),
		.page_ignored   (page_ignored)
	);

endmodule
`default_nettype wire

// ===== rtl/core/gcrmt_ctrl.sv =====
// Controller state machine of the grid column/row maximum tracker.
`timescale 1ns / 1ps
`default_nettype none
module gcrmt_ctrl
	import gcrmt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.finish = 1'b0;
		busy       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/gcrmt_dpath.sv =====
// Datapath of the grid column/row maximum tracker: registers, tables and results.
`timescale 1ns / 1ps
`default_nettype none
module gcrmt_dpath
	import gcrmt_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ctrl_cmd_t                     cmd,
	input  wire logic [1:0]                    opcode,
	input  wire logic [DIM_BITS-1:0]           page_width,
	input  wire logic [DIM_BITS-1:0]           page_height,
	input  wire logic [ROW_BITS-1:0]           query_index,
	input  wire logic                          wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]       wr_index,
	input  wire logic [CFG_DAT_BITS-1:0]       wr_data,
	output logic                               done,
	output logic signed [VALUE_BITS-1:0]       value,
	output logic [COL_BITS-1:0]                placed_column,
	output logic [ROW_BITS-1:0]                placed_row,
	output logic [NCOL_BITS-1:0]               columns_in_use,
	output logic [COL_BITS-1:0]                offset_in_use,
	output logic [COUNT_BITS-1:0]              rows_in_use,
	output logic                               page_ignored
);

	// Rows touched: the row holding the next cell counts once a page sits in it.
	function automatic logic [COUNT_BITS-1:0] rows_touched(
		input logic [COUNT_BITS-1:0] placed,
		input logic [COL_BITS-1:0]   col,
		input logic [COUNT_BITS-1:0] row
	);
		logic [COUNT_BITS-1:0] r;
		if (placed == '0) begin
			r = '0;
		end else if (col == '0) begin
			r = row;
		end else begin
			r = row + COUNT_BITS'(1);
		end
		return r;
	endfunction

	// Configuration registers.
	logic [NCOL_BITS-1:0]  req_cols_q;
	logic [COL_BITS-1:0]   req_off_q;
	logic [COUNT_BITS-1:0] page_count_q;

	// Grid state.
	logic [COUNT_BITS-1:0] page_limit_q;
	logic [COUNT_BITS-1:0] pages_placed_q;
	logic [COL_BITS-1:0]   cur_col_q;
	logic [COUNT_BITS-1:0] cur_row_q;
	logic [NCOL_BITS-1:0]  eff_cols_q;
	logic [COL_BITS-1:0]   eff_off_q;
	logic [MAX_COLUMNS-1:0] col_filled_q;

	// Latched item.
	opcode_t               op_q;
	logic [DIM_BITS-1:0]   width_q;
	logic [DIM_BITS-1:0]   height_q;
	logic [ROW_BITS-1:0]   query_q;

	// Tables.
	logic [DIM_BITS-1:0] col_mem [MAX_COLUMNS];
	logic [DIM_BITS-1:0] row_mem [MAX_PAGES];
	logic [DIM_BITS-1:0] col_rd_q;
	logic [DIM_BITS-1:0] row_rd_q;
	logic [COL_BITS-1:0] col_addr;
	logic [ROW_BITS-1:0] row_addr;

	// Next-state values computed in the finish cycle.
	logic [COUNT_BITS-1:0] limit_d;
	logic [COUNT_BITS-1:0] clamp_cols;
	logic [NCOL_BITS-1:0]  cols_d;
	logic [COL_BITS-1:0]   cols_m1;
	logic [COL_BITS-1:0]   off_d;
	logic                  place_ok;
	logic [NCOL_BITS-1:0]  col_inc;
	logic                  col_wr;
	logic                  row_wr;
	logic                  row_was_filled;
	logic [COUNT_BITS-1:0] placed_n;
	logic [COL_BITS-1:0]   col_n;
	logic [COUNT_BITS-1:0] row_n;
	logic [NCOL_BITS-1:0]  eff_cols_n;
	logic [COL_BITS-1:0]   eff_off_n;
	logic [COUNT_BITS-1:0] rows_now;
	logic signed [VALUE_BITS-1:0] value_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_cols_q   <= NCOL_BITS'(1);
			req_off_q    <= '0;
			page_count_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_REQ_COLUMNS: req_cols_q   <= wr_data[NCOL_BITS-1:0];
				REG_REQ_OFFSET:  req_off_q    <= wr_data[COL_BITS-1:0];
				REG_PAGE_COUNT:  page_count_q <= wr_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode_t'(opcode);
			width_q  <= page_width;
			height_q <= page_height;
			query_q  <= query_index;
		end
	end

	// Pages read their own cell; queries read the asked entry.
	assign col_addr = (op_q == OP_PLACE) ? cur_col_q : query_q[COL_BITS-1:0];
	assign row_addr = (op_q == OP_PLACE) ? cur_row_q[ROW_BITS-1:0] : query_q;

	always_ff @(posedge clk) begin
		col_rd_q <= col_mem[col_addr];
		if (cmd.finish && col_wr) begin
			col_mem[cur_col_q] <= width_q;
		end
	end

	always_ff @(posedge clk) begin
		row_rd_q <= row_mem[row_addr];
		if (cmd.finish && row_wr) begin
			row_mem[cur_row_q[ROW_BITS-1:0]] <= height_q;
		end
	end

	always_comb begin
		// Restart clamping.
		limit_d = (page_count_q > COUNT_BITS'(MAX_PAGES)) ? COUNT_BITS'(MAX_PAGES)
			: page_count_q;
		clamp_cols = (COUNT_BITS'(req_cols_q) > limit_d) ? limit_d
			: COUNT_BITS'(req_cols_q);
		if (clamp_cols > COUNT_BITS'(MAX_COLUMNS)) begin
			clamp_cols = COUNT_BITS'(MAX_COLUMNS);
		end
		if (clamp_cols == '0) begin
			clamp_cols = COUNT_BITS'(1);
		end
		cols_d  = clamp_cols[NCOL_BITS-1:0];
		cols_m1 = COL_BITS'(cols_d - NCOL_BITS'(1));
		off_d   = (req_off_q > cols_m1) ? cols_m1 : req_off_q;

		// Page placement.
		place_ok = (pages_placed_q < page_limit_q) && !cur_row_q[COUNT_BITS-1];
		row_was_filled = (pages_placed_q != '0) && (cur_col_q != '0);
		col_wr = (op_q == OP_PLACE) && place_ok
			&& (!col_filled_q[cur_col_q] || (col_rd_q < width_q));
		row_wr = (op_q == OP_PLACE) && place_ok
			&& (!row_was_filled || (row_rd_q < height_q));
		col_inc = NCOL_BITS'(cur_col_q) + NCOL_BITS'(1);

		placed_n   = pages_placed_q;
		col_n      = cur_col_q;
		row_n      = cur_row_q;
		eff_cols_n = eff_cols_q;
		eff_off_n  = eff_off_q;
		case (op_q)
			OP_RESTART: begin
				placed_n   = '0;
				col_n      = off_d;
				row_n      = '0;
				eff_cols_n = cols_d;
				eff_off_n  = off_d;
			end
			OP_PLACE: begin
				if (place_ok) begin
					placed_n = pages_placed_q + COUNT_BITS'(1);
					if (col_inc >= eff_cols_q) begin
						col_n = '0;
						row_n = cur_row_q + COUNT_BITS'(1);
					end else begin
						col_n = col_inc[COL_BITS-1:0];
					end
				end
			end
			default: begin
			end
		endcase

		rows_now = rows_touched(pages_placed_q, cur_col_q, cur_row_q);
		value_d  = '1;
		case (op_q)
			OP_READ_COL: begin
				if ((query_q < ROW_BITS'(eff_cols_q)) && col_filled_q[query_q[COL_BITS-1:0]]) begin
					value_d = {1'b0, col_rd_q};
				end
			end
			OP_READ_ROW: begin
				if (COUNT_BITS'(query_q) < rows_now) begin
					value_d = {1'b0, row_rd_q};
				end
			end
			default: begin
				value_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q   <= '0;
			pages_placed_q <= '0;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			eff_cols_q     <= NCOL_BITS'(1);
			eff_off_q      <= '0;
			col_filled_q   <= '0;
			done           <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.finish) begin
				pages_placed_q <= placed_n;
				cur_col_q      <= col_n;
				cur_row_q      <= row_n;
				eff_cols_q     <= eff_cols_n;
				eff_off_q      <= eff_off_n;
				if (op_q == OP_RESTART) begin
					page_limit_q <= limit_d;
					col_filled_q <= '0;
				end else if (col_wr) begin
					col_filled_q[cur_col_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			value          <= value_d;
			placed_column  <= ((op_q == OP_PLACE) && place_ok) ? cur_col_q : '0;
			placed_row     <= ((op_q == OP_PLACE) && place_ok)
				? cur_row_q[ROW_BITS-1:0] : '0;
			columns_in_use <= eff_cols_n;
			offset_in_use  <= eff_off_n;
			rows_in_use    <= rows_touched(placed_n, col_n, row_n);
			page_ignored   <= (op_q == OP_PLACE) && !place_ok;
		end
	end

endmodule
`default_nettype wire
